// ----- hw/rtl/quad_motor_mixer_macros.svh -----
// Assertion helpers shared by the mixer RTL.
`ifndef QUAD_MOTOR_MIXER_MACROS_SVH
`define QUAD_MOTOR_MIXER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define QMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define QMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define QMM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QMM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/qmm_pkg.sv -----
package qmm_pkg;

   localparam int FIELD_W      = 32;
   localparam int QUARTER_W    = FIELD_W - 2;
   localparam int GAIN_W       = 32;
   localparam int RECIP_W      = 40;
   localparam int RECIP_HALF_W = RECIP_W / 2;
   localparam int SPEED_W      = 32;
   localparam int MOTORS       = 4;
   localparam int GAIN_PROD_W  = 64;
   localparam int SQ_W         = 64;
   localparam int SQRT_STEPS   = SPEED_W;
   localparam int MIX_STAGES   = 2;
   localparam int MUL_STAGES   = 2;
   localparam int LANE_STAGES  = MUL_STAGES + SQRT_STEPS;
   localparam int PIPE_STAGES  = MIX_STAGES + LANE_STAGES;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = RECIP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TYPE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PLUS_ARM      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X_ARM         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_YAW           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_THRUST_COEFF = 3'd4;

   typedef struct packed {
      logic              frame_type;
      logic [GAIN_W-1:0] gain_plus_arm;
      logic [GAIN_W-1:0] gain_x_arm;
      logic [GAIN_W-1:0] gain_yaw;
   } mix_cfg_type;

   // Width of a clamped (nonnegative) rotor force magnitude.
   function automatic int force_width(input int frac_bits);
      return GAIN_PROD_W + 1 - frac_bits;
   endfunction

endpackage

// ----- hw/rtl/qmm_if.sv -----
interface qmm_req_if import qmm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] thrust;
   logic signed [FIELD_W-1:0] torque_roll;
   logic signed [FIELD_W-1:0] torque_pitch;
   logic signed [FIELD_W-1:0] torque_yaw;

   modport source (
      output valid, thrust, torque_roll, torque_pitch, torque_yaw,
      input  ready
   );
   modport sink (
      input  valid, thrust, torque_roll, torque_pitch, torque_yaw,
      output ready
   );
endinterface

interface qmm_rsp_if import qmm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_motor0;
   logic [SPEED_W-1:0] speed_motor1;
   logic [SPEED_W-1:0] speed_motor2;
   logic [SPEED_W-1:0] speed_motor3;

   modport source (
      output valid, speed_motor0, speed_motor1, speed_motor2, speed_motor3,
      input  ready
   );
   modport sink (
      input  valid, speed_motor0, speed_motor1, speed_motor2, speed_motor3,
      output ready
   );
endinterface

// ----- hw/rtl/quad_motor_mixer.sv -----
// Quadrotor motor mixer, plus and X frame.
// Pipeline: 2 mixing stages, then four lanes, one per rotor, each with 2 multiply
//   stages and a 32-stage square-root pipe.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous; empties the pipeline and loads default configuration.
`include "quad_motor_mixer_macros.svh"

module quad_motor_mixer import qmm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   qmm_req_if.sink               req_ch,
   qmm_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W = force_width(FRAC_BITS);
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << FRAC_BITS;
   localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << FRAC_BITS;

   mix_cfg_type          cfg_ff, cfg_in;
   logic [RECIP_W-1:0]   recip_ff, recip_in;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in, valid_prev, pipe_en;
   logic                   in_xfer, out_xfer;

   logic [POS_W-1:0]       rotor_force [MOTORS];
   logic [SPEED_W-1:0]     speed [MOTORS];

   // Register writes
   always_comb begin
      cfg_in   = cfg_ff;
      recip_in = recip_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_TYPE:         cfg_in.frame_type    = csr_wdata[0];
            CSR_GAIN_PLUS_ARM:      cfg_in.gain_plus_arm = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_X_ARM:         cfg_in.gain_x_arm    = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_YAW:           cfg_in.gain_yaw      = csr_wdata[GAIN_W-1:0];
            CSR_RECIP_THRUST_COEFF: recip_in             = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_type    <= 1'b0;
         cfg_ff.gain_plus_arm <= GAIN_ONE;
         cfg_ff.gain_x_arm    <= GAIN_ONE;
         cfg_ff.gain_yaw      <= GAIN_ONE;
         recip_ff             <= RECIP_ONE;
      end else begin
         cfg_ff   <= cfg_in;
         recip_ff <= recip_in;
      end
   end

   // Stage k advances when the output drains or any stage from k onward is a bubble.
   for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_en
      assign pipe_en[k] = rsp_ch.ready | ~(&valid_ff[PIPE_STAGES-1:k]);
   end

   always_comb begin
      valid_prev = {valid_ff[PIPE_STAGES-2:0], req_ch.valid};
      valid_in   = (pipe_en & valid_prev) | (~pipe_en & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = pipe_en[0];
   assign rsp_ch.valid = valid_ff[PIPE_STAGES-1];
   assign in_xfer      = req_ch.valid & req_ch.ready;
   assign out_xfer     = rsp_ch.valid & rsp_ch.ready;

   qmm_mix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mix (
      .clock        (clock),
      .stage_en     (pipe_en[MIX_STAGES-1:0]),
      .cfg          (cfg_ff),
      .thrust       (req_ch.thrust),
      .torque_roll  (req_ch.torque_roll),
      .torque_pitch (req_ch.torque_pitch),
      .torque_yaw   (req_ch.torque_yaw),
      .rotor_force  (rotor_force)
   );

   for (genvar m = 0; m < MOTORS; m++) begin : g_lane
      qmm_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock              (clock),
         .stage_en           (pipe_en[PIPE_STAGES-1:MIX_STAGES]),
         .rotor_force        (rotor_force[m]),
         .recip_thrust_coeff (recip_ff),
         .speed              (speed[m])
      );
   end

   // Merge the four lanes into one result.
   assign rsp_ch.speed_motor0 = speed[0];
   assign rsp_ch.speed_motor1 = speed[1];
   assign rsp_ch.speed_motor2 = speed[2];
   assign rsp_ch.speed_motor3 = speed[3];

   `QMM_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, valid_ff == '0)
   `QMM_ASSERT_NEXT(a_fill, clock, reset, in_xfer && !out_xfer,
      $countones(valid_ff) == $past($countones(valid_ff)) + 1)
   `QMM_ASSERT_NEXT(a_drain, clock, reset, !in_xfer && out_xfer,
      $countones(valid_ff) + 1 == $past($countones(valid_ff)))
   `QMM_ASSERT_NEXT(a_balance, clock, reset, in_xfer == out_xfer,
      $countones(valid_ff) == $past($countones(valid_ff)))
   `QMM_ASSERT_IMPLIES(a_ready_on_bubble, clock, reset, !(&valid_ff), req_ch.ready)

endmodule

// ----- hw/rtl/qmm_mix.sv -----
module qmm_mix import qmm_pkg::*; #(
   parameter int  FRAC_BITS = 16,
   localparam int POS_W     = force_width(FRAC_BITS)
) (
   input  logic                      clock,
   input  logic [MIX_STAGES-1:0]     stage_en,
   input  mix_cfg_type               cfg,
   input  logic signed [FIELD_W-1:0] thrust,
   input  logic signed [FIELD_W-1:0] torque_roll,
   input  logic signed [FIELD_W-1:0] torque_pitch,
   input  logic signed [FIELD_W-1:0] torque_yaw,
   output logic [POS_W-1:0]          rotor_force [MOTORS]
);

   localparam int TERM_W  = GAIN_PROD_W - FRAC_BITS;
   localparam int FORCE_W = POS_W + 1;
   localparam int EXT_W   = FIELD_W + 1;

   logic [GAIN_W-1:0]               arm_gain;
   logic signed [EXT_W-1:0]         roll_x, pitch_x, yaw_x, arm_x, yaw_gain_x;
   logic signed [2*EXT_W-1:0]       roll_full, pitch_full, yaw_full;
   logic signed [GAIN_PROD_W-1:0]   roll_prod_in, pitch_prod_in, yaw_prod_in;
   logic signed [GAIN_PROD_W-1:0]   roll_prod_ff, pitch_prod_ff, yaw_prod_ff;
   logic signed [QUARTER_W-1:0]     quarter_in, quarter_ff;

   logic signed [GAIN_PROD_W-1:0]   roll_shift, pitch_shift, yaw_shift;
   logic signed [FORCE_W-1:0]       q_s, r_s, p_s, y_s, rx_s, px_s;
   logic signed [FORCE_W-1:0]       sum [MOTORS];
   logic [POS_W-1:0]                force_in [MOTORS];
   logic [POS_W-1:0]                force_ff [MOTORS];

   // Stage 1: gain products, signed command times unsigned gain, and thrust / 4.
   always_comb begin
      arm_gain      = cfg.frame_type ? cfg.gain_x_arm : cfg.gain_plus_arm;
      roll_x        = {torque_roll[FIELD_W-1], torque_roll};
      pitch_x       = {torque_pitch[FIELD_W-1], torque_pitch};
      yaw_x         = {torque_yaw[FIELD_W-1], torque_yaw};
      arm_x         = $signed({1'b0, arm_gain});
      yaw_gain_x    = $signed({1'b0, cfg.gain_yaw});
      roll_full     = roll_x * arm_x;
      pitch_full    = pitch_x * arm_x;
      yaw_full      = yaw_x * yaw_gain_x;
      roll_prod_in  = roll_full[GAIN_PROD_W-1:0];
      pitch_prod_in = pitch_full[GAIN_PROD_W-1:0];
      yaw_prod_in   = yaw_full[GAIN_PROD_W-1:0];
      // thrust / 4, floored
      quarter_in    = thrust[FIELD_W-1:2];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         roll_prod_ff  <= roll_prod_in;
         pitch_prod_ff <= pitch_prod_in;
         yaw_prod_ff   <= yaw_prod_in;
         quarter_ff    <= quarter_in;
      end
   end

   // Stage 2: floor to fixed point, mix, clamp negative forces.
   always_comb begin
      roll_shift  = roll_prod_ff >>> FRAC_BITS;
      pitch_shift = pitch_prod_ff >>> FRAC_BITS;
      yaw_shift   = yaw_prod_ff >>> FRAC_BITS;
      q_s  = {{(FORCE_W-QUARTER_W){quarter_ff[QUARTER_W-1]}}, quarter_ff};
      r_s  = {{2{roll_shift[TERM_W-1]}}, roll_shift[TERM_W-1:0]};
      p_s  = {{2{pitch_shift[TERM_W-1]}}, pitch_shift[TERM_W-1:0]};
      y_s  = {{2{yaw_shift[TERM_W-1]}}, yaw_shift[TERM_W-1:0]};
      // X frame also mixes the signed cross-axis arm term into each rotor
      rx_s = cfg.frame_type ? r_s : '0;
      px_s = cfg.frame_type ? p_s : '0;
      sum[0] = q_s - p_s + y_s + rx_s;
      sum[1] = q_s - r_s - y_s - px_s;
      sum[2] = q_s + p_s + y_s - rx_s;
      sum[3] = q_s + r_s - y_s + px_s;
      for (int m = 0; m < MOTORS; m++) begin
         force_in[m] = sum[m][FORCE_W-1] ? '0 : sum[m][POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int m = 0; m < MOTORS; m++) begin
            force_ff[m] <= force_in[m];
         end
      end
   end

   assign rotor_force = force_ff;

endmodule

// ----- hw/rtl/qmm_lane.sv -----
module qmm_lane import qmm_pkg::*; #(
   parameter int  FRAC_BITS = 16,
   localparam int POS_W     = force_width(FRAC_BITS)
) (
   input  logic                   clock,
   input  logic [LANE_STAGES-1:0] stage_en,
   input  logic [POS_W-1:0]       rotor_force,
   input  logic [RECIP_W-1:0]     recip_thrust_coeff,
   output logic [SPEED_W-1:0]     speed
);

   localparam int HALF_W  = (POS_W + 1) / 2;
   localparam int PP_W    = HALF_W + RECIP_HALF_W;
   localparam int PROD_W  = 2 * PP_W;
   localparam int REM_W   = SPEED_W + 1;
   localparam int TRIAL_W = REM_W + 2;

   logic [2*HALF_W-1:0]     force_pad;
   logic [HALF_W-1:0]       force_lo, force_hi;
   logic [RECIP_HALF_W-1:0] recip_lo, recip_hi;
   logic [PP_W-1:0]         pp_in [4];
   logic [PP_W-1:0]         pp_ff [4];
   logic [PROD_W-1:0]       prod;
   logic [SQ_W-1:0]         sq_in, sq_ff;
   logic                    over_sq_in, over_sq_ff;

   logic [REM_W-1:0]        rem_ff  [SQRT_STEPS];
   logic [SPEED_W-1:0]      root_ff [SQRT_STEPS];
   logic [SQ_W-1:0]         rad_ff  [SQRT_STEPS];
   logic                    over_ff [SQRT_STEPS];

   // Force times 1/kF, split into four narrow partial products.
   always_comb begin
      force_pad = (2*HALF_W)'(rotor_force);
      force_lo  = force_pad[HALF_W-1:0];
      force_hi  = force_pad[2*HALF_W-1:HALF_W];
      recip_lo  = recip_thrust_coeff[RECIP_HALF_W-1:0];
      recip_hi  = recip_thrust_coeff[RECIP_W-1:RECIP_HALF_W];
      pp_in[0]  = force_lo * recip_lo;
      pp_in[1]  = force_lo * recip_hi;
      pp_in[2]  = force_hi * recip_lo;
      pp_in[3]  = force_hi * recip_hi;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 4; i++) begin
            pp_ff[i] <= pp_in[i];
         end
      end
   end

   always_comb begin
      prod = PROD_W'(pp_ff[0])
           + (PROD_W'(pp_ff[1]) << RECIP_HALF_W)
           + (PROD_W'(pp_ff[2]) << HALF_W)
           + (PROD_W'(pp_ff[3]) << PP_W);
      sq_in      = prod[SQ_W-1:0];
      over_sq_in = |prod[PROD_W-1:SQ_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sq_ff      <= sq_in;
         over_sq_ff <= over_sq_in;
      end
   end

   // Restoring square root, one result bit per stage.
   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      logic [REM_W-1:0]   rem_prev, rem_in;
      logic [SPEED_W-1:0] root_prev, root_in;
      logic [SQ_W-1:0]    rad_prev;
      logic               over_prev, take;
      logic [TRIAL_W-1:0] rem_sh, trial, rem_sub;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = sq_ff;
         assign over_prev = over_sq_ff;
      end else begin : g_rest
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign over_prev = over_ff[s-1];
      end

      always_comb begin
         rem_sh  = {rem_prev, rad_prev[SQ_W-1 -: 2]};
         trial   = TRIAL_W'({root_prev, 2'b01});
         take    = rem_sh >= trial;
         rem_sub = rem_sh - trial;
         rem_in  = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_prev[SPEED_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (stage_en[MUL_STAGES+s]) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_prev << 2;
            over_ff[s] <= over_prev;
         end
      end
   end

   assign speed = over_ff[SQRT_STEPS-1] ? '1 : root_ff[SQRT_STEPS-1];

endmodule
